@@ hdl/lapg_pkg.sv @@
// ----------------------------------------------------------------------------
// lapg_pkg
// Shared constants and controller/datapath interface types for the
// RGB Laplacian-of-Gaussian filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lapg_pkg;

   // Filter geometry
   localparam int RADIUS     = 2;
   localparam int TAPS       = 2 * RADIUS + 1;
   localparam int POINTS     = 5;
   localparam int LINES      = 2 * RADIUS + 4;
   localparam int LINE_SEL_W = $clog2(LINES);

   // Field and counter widths
   localparam int W_PIX = 8;
   localparam int W_COL = 11;
   localparam int W_ROW = 12;
   localparam int W_HGT = 13;
   localparam int W_POS = 22;
   localparam int W_WGT = 17;
   localparam int W_RES = 19;
   localparam int W_STEP = 3;

   localparam logic [W_STEP-1:0] STEP_LAST = W_STEP'(TAPS - 1);
   localparam logic [W_STEP-1:0] POINT_LAST = W_STEP'(POINTS - 1);
   localparam logic [W_HGT-1:0] MAX_HEIGHT = 13'd4096;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VWGT_CENTRE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VWGT_ONE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VWGT_TWO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HWGT_CENTRE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HWGT_ONE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HWGT_TWO     = 3'd7;

   // Reset values of the configuration registers
   localparam logic [W_COL-1:0] RST_FRAME_WIDTH  = 11'd512;
   localparam logic [W_HGT-1:0] RST_FRAME_HEIGHT = 13'd512;
   localparam logic [W_WGT-1:0] RST_WGT_CENTRE   = 17'd16474;
   localparam logic [W_WGT-1:0] RST_WGT_ONE      = 17'd14538;
   localparam logic [W_WGT-1:0] RST_WGT_TWO      = 17'd9993;

   typedef struct packed {
      logic              wr_en;
      logic              adv_in;
      logic              div_start;
      logic              load_pos;
      logic              issue_valid;
      logic [W_STEP-1:0] issue_p;
      logic [W_STEP-1:0] issue_b;
      logic [W_STEP-1:0] issue_a;
      logic              load_out;
      logic              out_last;
      logic              adv_out;
      logic              clr_out;
   } lapg_cmd_type;

   typedef struct packed {
      logic col_wrap;
      logic row_wrap;
      logic emit_ok;
      logic last;
      logic div_done;
      logic lap_done;
   } lapg_stat_type;

endpackage

`default_nettype wire

@@ hdl/lapg_div.sv @@
// ----------------------------------------------------------------------------
// lapg_div
// Restoring divider, one quotient bit per cycle: splits the output raster
// index into row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module lapg_div import lapg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [W_POS-1:0] dividend,
   input  logic [W_COL-1:0] divisor,
   output logic [W_POS-1:0] quotient,
   output logic [W_COL-1:0] remainder,
   output logic             done
);

   localparam int CNT_W = $clog2(W_POS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W_POS - 1);

   logic [W_POS-1:0] quo_ff, quo_in;
   logic [W_COL-1:0] rem_ff, rem_in;
   logic [W_COL-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [W_COL:0]   trial;
   logic [W_COL:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[W_POS-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = diff[W_COL-1:0];
         quo_in = {quo_ff[W_POS-2:0], 1'b1};
      end else begin
         rem_in = trial[W_COL-1:0];
         quo_in = {quo_ff[W_POS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

@@ hdl/lapg_ctrl.sv @@
// ----------------------------------------------------------------------------
// lapg_ctrl
// Item sequencer: handshakes, frame bookkeeping, and the step counters that
// walk the 5 points x 5 columns x 5 rows of line-store reads per result.
// ----------------------------------------------------------------------------
`default_nettype none

module lapg_ctrl import lapg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_mode,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output lapg_cmd_type  cmd,
   input  lapg_stat_type st
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATH,
      ST_DIV,
      ST_RUN,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   logic              frame_done_ff, frame_done_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W_STEP-1:0] p_ff, p_in;
   logic [W_STEP-1:0] b_ff, b_in;
   logic [W_STEP-1:0] a_ff, a_in;
   logic              accept;
   logic              out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd             = '0;
      cmd.wr_en       = accept && !req_mode && !frame_done_ff;
      cmd.adv_in      = (state_ff == ST_MATH) && !mode_ff;
      cmd.div_start   = (state_ff == ST_MATH) && (mode_ff || st.emit_ok);
      cmd.load_pos    = (state_ff == ST_DIV) && st.div_done;
      cmd.issue_valid = (state_ff == ST_RUN);
      cmd.issue_p     = p_ff;
      cmd.issue_b     = b_ff;
      cmd.issue_a     = a_ff;
      cmd.load_out    = (state_ff == ST_OUT) && out_free;
      cmd.out_last    = last_ff;
      cmd.adv_out     = cmd.load_out && !last_ff;
      cmd.clr_out     = cmd.load_out && last_ff;

      state_in      = state_ff;
      mode_in       = mode_ff;
      frame_done_in = frame_done_ff;
      last_in       = last_ff;
      p_in          = p_ff;
      b_in          = b_ff;
      a_in          = a_ff;
      rsp_valid_in  = cmd.load_out || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         ST_IDLE: begin
            // A pixel after the frame end or a drain before it is dropped.
            if (accept && (req_mode == frame_done_ff)) begin
               mode_in  = req_mode;
               state_in = ST_MATH;
            end
         end
         ST_MATH: begin
            if (mode_ff) begin
               last_in  = st.last;
               state_in = ST_DIV;
            end else begin
               last_in = 1'b0;
               if (st.col_wrap && st.row_wrap) begin
                  frame_done_in = 1'b1;
               end
               state_in = st.emit_ok ? ST_DIV : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (st.div_done) begin
               p_in     = '0;
               b_in     = '0;
               a_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (a_ff == STEP_LAST) begin
               a_in = '0;
               if (b_ff == STEP_LAST) begin
                  b_in = '0;
                  if (p_ff == POINT_LAST) begin
                     state_in = ST_WAIT;
                  end else begin
                     p_in = p_ff + 1'b1;
                  end
               end else begin
                  b_in = b_ff + 1'b1;
               end
            end else begin
               a_in = a_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (st.lap_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               if (last_ff) begin
                  frame_done_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= 1'b0;
         frame_done_ff <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         p_ff          <= '0;
         b_ff          <= '0;
         a_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         frame_done_ff <= frame_done_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
         p_ff          <= p_in;
         b_ff          <= b_in;
         a_ff          <= a_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/lapg_dp.sv @@
// ----------------------------------------------------------------------------
// lapg_dp
// Datapath: configuration registers, raster counters, raw line store and the
// pipelined vertical/horizontal blur and Laplacian accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module lapg_dp import lapg_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lapg_cmd_type            cmd,
   output lapg_stat_type           st,
   input  logic [W_PIX-1:0]        pixel_red,
   input  logic [W_PIX-1:0]        pixel_green,
   input  logic [W_PIX-1:0]        pixel_blue,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [W_WGT-1:0]        csr_data,
   output logic signed [W_RES-1:0] result_red,
   output logic signed [W_RES-1:0] result_green,
   output logic signed [W_RES-1:0] result_blue,
   output logic                    last_pixel
);

   localparam int DEPTH = LINES * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int WCAP  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
   localparam logic [AW-1:0]    LINE_STRIDE = AW'(MAX_WIDTH);
   localparam logic [W_COL-1:0] WCAP_V      = W_COL'(WCAP);
   localparam int W_V = 28;
   localparam int W_H = 45;
   localparam int W_S = 48;
   localparam int W_B = 16;

   typedef struct packed {
      logic       valid;
      logic [1:0] wsel_v;
      logic [1:0] wsel_h;
      logic       first_a;
      logic       last_a;
      logic       first_b;
      logic       last_b;
      logic       first_p;
      logic       last_p;
      logic       centre;
   } tag_type;

   function automatic logic [W_HGT-1:0] mirror(input logic signed [14:0] j,
                                                input logic [W_HGT-1:0] n);
      logic signed [14:0] k;
      logic signed [14:0] ns;
      begin
         ns = $signed({2'b00, n});
         k  = (j < 0) ? -j : j;
         if (k >= ns) begin
            k = ns + ns - 15'sd2 - k;
         end
         return k[W_HGT-1:0];
      end
   endfunction

   function automatic logic [1:0] tap_dist(input logic [W_STEP-1:0] s);
      logic [1:0] d;
      begin
         case (s)
            3'd0, 3'd4: d = 2'd2;
            3'd1, 3'd3: d = 2'd1;
            default:    d = 2'd0;
         endcase
         return d;
      end
   endfunction

   // Configuration
   logic [W_COL-1:0] fw_ff;
   logic [W_HGT-1:0] fh_ff;
   logic [W_WGT-1:0] vw_ff [3];
   logic [W_WGT-1:0] hw_ff [3];
   logic [W_COL-1:0] w_eff;
   logic [W_HGT-1:0] h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= RST_FRAME_WIDTH;
         fh_ff    <= RST_FRAME_HEIGHT;
         vw_ff[0] <= RST_WGT_CENTRE;
         vw_ff[1] <= RST_WGT_ONE;
         vw_ff[2] <= RST_WGT_TWO;
         hw_ff[0] <= RST_WGT_CENTRE;
         hw_ff[1] <= RST_WGT_ONE;
         hw_ff[2] <= RST_WGT_TWO;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff    <= csr_data[W_COL-1:0];
            CSR_FRAME_HEIGHT: fh_ff    <= csr_data[W_HGT-1:0];
            CSR_VWGT_CENTRE:  vw_ff[0] <= csr_data;
            CSR_VWGT_ONE:     vw_ff[1] <= csr_data;
            CSR_VWGT_TWO:     vw_ff[2] <= csr_data;
            CSR_HWGT_CENTRE:  hw_ff[0] <= csr_data;
            CSR_HWGT_ONE:     hw_ff[1] <= csr_data;
            CSR_HWGT_TWO:     hw_ff[2] <= csr_data;
         endcase
      end
   end

   always_comb begin
      if (fw_ff < W_COL'(3)) begin
         w_eff = W_COL'(3);
      end else if (fw_ff > WCAP_V) begin
         w_eff = WCAP_V;
      end else begin
         w_eff = fw_ff;
      end
      if (fh_ff < W_HGT'(3)) begin
         h_eff = W_HGT'(3);
      end else if (fh_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = fh_ff;
      end
   end

   // Raster counters and frame products
   logic [W_COL-1:0] in_col_ff;
   logic [W_ROW-1:0] in_row_ff;
   logic [W_POS-1:0] out_pos_ff;
   logic [22:0]      qprod_ff;
   logic [23:0]      area_ff;

   always_ff @(posedge clock) begin
      qprod_ff <= 23'(in_row_ff) * 23'(w_eff);
      area_ff  <= 24'(w_eff) * 24'(h_eff);
   end

   assign st.col_wrap = (12'(in_col_ff) + 12'd1) >= 12'(w_eff);
   assign st.row_wrap = (13'(in_row_ff) + 13'd1) >= h_eff;
   // Results start once the input is three rows and three pixels ahead.
   assign st.emit_ok  = (24'(qprod_ff) + 24'(in_col_ff)) >= (24'(w_eff) * 24'd3 + 24'd3);
   assign st.last     = (24'(out_pos_ff) + 24'd1) >= area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_pos_ff <= '0;
      end else begin
         if (cmd.adv_in) begin
            if (st.col_wrap) begin
               in_col_ff <= '0;
               in_row_ff <= st.row_wrap ? '0 : in_row_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (cmd.clr_out) begin
            out_pos_ff <= '0;
         end else if (cmd.adv_out) begin
            out_pos_ff <= out_pos_ff + 1'b1;
         end
      end
   end

   // Output position to row and column
   logic [W_POS-1:0] quo;
   logic [W_COL-1:0] rem;
   logic             div_done;

   lapg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (out_pos_ff),
      .divisor   (w_eff),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   assign st.div_done = div_done;

   logic [W_HGT-1:0] h_m1;
   logic [W_ROW-1:0] r_cl, up_v, dn_v;
   logic [W_COL-1:0] lf_v, rt_v;
   logic [W_ROW-1:0] r_ff, up_ff, dn_ff;
   logic [W_COL-1:0] c_ff, lf_ff, rt_ff;

   always_comb begin
      h_m1 = h_eff - 1'b1;
      r_cl = (quo > W_POS'(h_m1)) ? h_m1[W_ROW-1:0] : quo[W_ROW-1:0];
      up_v = (r_cl == '0) ? W_ROW'(1) : r_cl - 1'b1;
      dn_v = ((13'(r_cl) + 13'd1) >= h_eff) ? W_ROW'(h_eff - 13'd2) : r_cl + 1'b1;
      lf_v = (rem == '0) ? W_COL'(1) : rem - 1'b1;
      rt_v = ((12'(rem) + 12'd1) >= 12'(w_eff)) ? w_eff - 11'd2 : rem + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pos) begin
         r_ff  <= r_cl;
         up_ff <= up_v;
         dn_ff <= dn_v;
         c_ff  <= rem;
         lf_ff <= lf_v;
         rt_ff <= rt_v;
      end
   end

   // Stage 0: reflected read coordinates
   logic [W_ROW-1:0]      pr;
   logic [W_COL-1:0]      pc;
   logic [W_HGT-1:0]      rr_full, cc_full;
   tag_type               t0;
   tag_type               t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   tag_type               t4_in, t6_in;
   logic [LINE_SEL_W-1:0] rr_ff;
   logic [W_COL-1:0]      cc_ff;

   always_comb begin
      case (cmd.issue_p)
         3'd0:    begin pr = up_ff; pc = c_ff;  end
         3'd1:    begin pr = dn_ff; pc = c_ff;  end
         3'd2:    begin pr = r_ff;  pc = lf_ff; end
         3'd3:    begin pr = r_ff;  pc = rt_ff; end
         default: begin pr = r_ff;  pc = c_ff;  end
      endcase
      rr_full = mirror($signed(15'(pr)) + $signed(15'(cmd.issue_a)) - 15'sd2, h_eff);
      cc_full = mirror($signed(15'(pc)) + $signed(15'(cmd.issue_b)) - 15'sd2,
                       W_HGT'(w_eff));
      t0.valid   = cmd.issue_valid;
      t0.wsel_v  = tap_dist(cmd.issue_a);
      t0.wsel_h  = tap_dist(cmd.issue_b);
      t0.first_a = (cmd.issue_a == '0);
      t0.last_a  = (cmd.issue_a == STEP_LAST);
      t0.first_b = (cmd.issue_b == '0);
      t0.last_b  = (cmd.issue_b == STEP_LAST);
      t0.first_p = (cmd.issue_p == '0);
      t0.last_p  = (cmd.issue_p == POINT_LAST);
      t0.centre  = (cmd.issue_p == POINT_LAST);
   end

   always_ff @(posedge clock) begin
      rr_ff <= rr_full[LINE_SEL_W-1:0];
      cc_ff <= cc_full[W_COL-1:0];
   end

   // Raw line store
   logic [3*W_PIX-1:0] raw_mem [DEPTH];
   logic [3*W_PIX-1:0] mem_q_ff;
   logic [AW-1:0]      wr_addr, rd_addr;

   assign wr_addr = AW'(in_row_ff[LINE_SEL_W-1:0]) * LINE_STRIDE + AW'(in_col_ff);
   assign rd_addr = AW'(rr_ff) * LINE_STRIDE + AW'(cc_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         raw_mem[wr_addr] <= {pixel_blue, pixel_green, pixel_red};
      end
      mem_q_ff <= raw_mem[rd_addr];
   end

   // Tag pipeline
   always_comb begin
      t4_in       = t3_ff;
      t4_in.valid = t3_ff.valid && t3_ff.last_a;
      t6_in       = t5_ff;
      t6_in.valid = t5_ff.valid && t5_ff.last_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
         t6_ff <= '0;
      end else begin
         t1_ff <= t0;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t4_in;
         t5_ff <= t4_ff;
         t6_ff <= t6_in;
      end
   end

   // Per-channel arithmetic lanes
   logic [W_V-1:0]          vacc_ff  [3];
   logic [W_H-1:0]          hprod_ff [3];
   logic [W_S-1:0]          sacc_ff  [3];
   logic [W_B-1:0]          blur_ff  [3];
   logic signed [W_RES-1:0] lap_ff   [3];
   logic signed [W_RES-1:0] rsp_ff   [3];
   logic                    rsp_last_ff;
   logic                    lap_done_ff;
   logic [W_WGT-1:0]        vw_sel, hw_sel;
   logic [24:0]             vprod    [3];
   logic [W_S:0]            rnd      [3];
   logic signed [W_RES-1:0] term     [3];

   assign vw_sel = vw_ff[t2_ff.wsel_v];
   assign hw_sel = hw_ff[t3_ff.wsel_h];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         vprod[ch] = 25'(vw_sel) * 25'(mem_q_ff[W_PIX*ch +: W_PIX]);
         rnd[ch]   = (W_S+1)'(sacc_ff[ch]) + (W_S+1)'(49'h80_0000);
         term[ch]  = t6_ff.centre ? -$signed({1'b0, blur_ff[ch], 2'b00})
                                  : $signed(W_RES'(blur_ff[ch]));
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (t2_ff.valid) begin
            vacc_ff[ch] <= (t2_ff.first_a ? '0 : vacc_ff[ch]) + W_V'(vprod[ch]);
         end
         if (t3_ff.valid && t3_ff.last_a) begin
            hprod_ff[ch] <= W_H'(hw_sel) * W_H'(vacc_ff[ch]);
         end
         if (t4_ff.valid) begin
            sacc_ff[ch] <= (t4_ff.first_b ? '0 : sacc_ff[ch]) + W_S'(hprod_ff[ch]);
         end
         if (t5_ff.valid && t5_ff.last_b) begin
            // Round Q.32 to Q8.8 and saturate.
            blur_ff[ch] <= (|rnd[ch][W_S:40]) ? '1 : rnd[ch][39:24];
         end
         if (t6_ff.valid) begin
            lap_ff[ch] <= (t6_ff.first_p ? '0 : lap_ff[ch]) + term[ch];
         end
         if (cmd.load_out) begin
            rsp_ff[ch] <= lap_ff[ch];
         end
      end
      if (cmd.load_out) begin
         rsp_last_ff <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lap_done_ff <= 1'b0;
      end else begin
         lap_done_ff <= t6_ff.valid && t6_ff.last_p;
      end
   end

   assign st.lap_done  = lap_done_ff;
   assign result_red   = rsp_ff[0];
   assign result_green = rsp_ff[1];
   assign result_blue  = rsp_ff[2];
   assign last_pixel   = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/laplacian_of_gaussian_rgb.sv @@
// ----------------------------------------------------------------------------
// laplacian_of_gaussian_rgb
// 5x5 separable Gaussian blur followed by a 4-neighbour Laplacian on each
// channel of a raster-order RGB stream, with mirrored borders.
//
//   channel  direction  handshake          contents
//   req_     in         valid / stall      mode, pixel_red/green/blue
//   rsp_     out        valid / stall      result_red/green/blue, last_pixel
//   csr_     in         valid / ready      index, data (register write)
//
// A pixel that yields no result is only accepted and decoded; an item with a
// result is accepted and decoded, then runs the row/column divider, the reads
// of the raw line store through its single read port, the pipeline drain and
// the load of the output register.
// Reset is synchronous; the line store is not cleared.
// A new item is taken while a result is still stalled; its own result waits
// in the datapath's Laplacian accumulators until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_of_gaussian_rgb import lapg_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [W_PIX-1:0]        req_pixel_red,
   input  logic [W_PIX-1:0]        req_pixel_green,
   input  logic [W_PIX-1:0]        req_pixel_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [W_RES-1:0] rsp_result_red,
   output logic signed [W_RES-1:0] rsp_result_green,
   output logic signed [W_RES-1:0] rsp_result_blue,
   output logic                    rsp_last_pixel,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [W_WGT-1:0]        csr_data
);

   lapg_cmd_type  cmd;
   lapg_stat_type st;

   assign csr_ready = 1'b1;

   lapg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st)
   );

   lapg_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .pixel_red    (req_pixel_red),
      .pixel_green  (req_pixel_green),
      .pixel_blue   (req_pixel_blue),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .result_red   (rsp_result_red),
      .result_green (rsp_result_green),
      .result_blue  (rsp_result_blue),
      .last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

@@ hdl/lapg_check.sv @@
// ----------------------------------------------------------------------------
// lapg_check
// Port-level checks for the Laplacian-of-Gaussian filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lapg_check import lapg_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [W_RES-1:0] rsp_result_red,
   input logic signed [W_RES-1:0] rsp_result_green,
   input logic signed [W_RES-1:0] rsp_result_blue,
   input logic                    rsp_last_pixel
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_red)
         && $stable(rsp_result_green) && $stable(rsp_result_blue)
         && $stable(rsp_last_pixel))
      else $error("stalled result changed");

   // No result can appear the cycle straight after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // A fresh result is loaded only while the input side is held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result loaded while idle");

   // Four neighbours minus four centres of a 16-bit blur stay in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_green <= 19'sd262140)
         && (rsp_result_green >= -19'sd262140))
      else $error("result out of range");

endmodule

bind laplacian_of_gaussian_rgb lapg_check u_lapg_check (.*);

`default_nettype wire
